// ----- rtl/s2da_pkg.sv -----
package s2da_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned NUM_DIGITS     = 10;
  localparam int unsigned BCD_W          = 4 * NUM_DIGITS;
  localparam int unsigned BITS_PER_STAGE = 4;
  localparam int unsigned DD_STAGES      = VALUE_W / BITS_PER_STAGE;
  localparam int unsigned IDX_W          = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // shift-and-add-3 working word: decimal digits above, binary bits below
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } dd_t;

  // finished conversion handed to the character serializer
  typedef struct packed {
    logic                         neg;
    logic [NUM_DIGITS-1:0][3:0]   digits;
    logic [IDX_W-1:0]             top_idx;
  } conv_t;

  // several shift-and-add-3 steps, one pipeline stage worth
  function automatic dd_t dd_steps(dd_t a);
    dd_t        r;
    logic [3:0] d;
    r = a;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        d = r.bcd[4*k +: 4];
        if (d >= 4'd5) begin
          r.bcd[4*k +: 4] = d + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    end
    return r;
  endfunction

  // position of the most significant nonzero digit, zero when all are zero
  function automatic logic [IDX_W-1:0] top_digit(logic [BCD_W-1:0] bcd);
    logic [IDX_W-1:0] hi;
    hi = '0;
    for (int k = 1; k < NUM_DIGITS; k++) begin
      if (bcd[4*k +: 4] != 4'd0) begin
        hi = IDX_W'(k);
      end
    end
    return hi;
  endfunction

endpackage

// ----- rtl/signed_int_to_decimal_ascii.sv -----
// throughput: one character per cycle while out_tready is high; a number
// has 1 to 11 characters, all sent by the one-character serializer
// the conversion pipeline takes a new number every cycle while it has room
// reset: synchronous, active low; clears all valid bits and the serializer's busy, sign and index
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic signed [31:0] in_tdata,  // [31:0] value
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,        // [7:0] ascii_char
  output logic        out_tlast         // last_char
);

  // conversion pipeline to serializer
  logic            conv_valid;
  logic            conv_ready;
  s2da_pkg::conv_t conv;

  // stage 0 forms sign and magnitude, eight stages of shift-and-add-3
  // turn the 32-bit magnitude into ten decimal digits, a last stage
  // finds the leading digit; valid bits move with each word
  s2da_conv u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_tvalid),
    .i_ready (in_tready),
    .i_value (in_tdata),
    .o_valid (conv_valid),
    .o_ready (conv_ready),
    .o_conv  (conv)
  );

  // walks the sign and digits out one character per word, most
  // significant first, with no leading zeros; zero gives a single '0'
  s2da_ser u_ser (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (conv_valid),
    .i_ready (conv_ready),
    .i_conv  (conv),
    .o_valid (out_tvalid),
    .o_ready (out_tready),
    .o_char  (out_tdata),
    .o_last  (out_tlast)
  );

endmodule

// ----- rtl/s2da_conv.sv -----
module s2da_conv (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  i_valid,
  output logic                                  i_ready,
  input  logic signed [s2da_pkg::VALUE_W-1:0]   i_value,
  output logic                                  o_valid,
  input  logic                                  o_ready,
  output s2da_pkg::conv_t                       o_conv
);

  // stage 0: magnitude, stages 1..DD_STAGES: conversion, last: leading digit index
  localparam int unsigned LAST = s2da_pkg::DD_STAGES + 1;

  logic            v_r   [0:LAST];
  logic            rdy   [0:LAST+1];
  logic            neg_r [0:LAST];
  s2da_pkg::dd_t   dd_r  [0:s2da_pkg::DD_STAGES];
  s2da_pkg::conv_t out_r;
  logic [s2da_pkg::VALUE_W-1:0] mag_nxt;

  always_comb begin
    rdy[LAST+1] = o_ready;
    for (int i = int'(LAST); i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign mag_nxt = i_value[s2da_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= int'(LAST); i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        v_r[0] <= i_valid;
      end
      for (int i = 1; i <= int'(LAST); i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      neg_r[0]      <= i_value[s2da_pkg::VALUE_W-1];
      dd_r[0].bcd   <= '0;
      dd_r[0].bin   <= mag_nxt;
    end
    for (int i = 1; i <= int'(s2da_pkg::DD_STAGES); i++) begin
      if (rdy[i]) begin
        neg_r[i] <= neg_r[i-1];
        dd_r[i]  <= s2da_pkg::dd_steps(dd_r[i-1]);
      end
    end
    if (rdy[LAST]) begin
      neg_r[LAST]   <= neg_r[LAST-1];
      out_r.neg     <= neg_r[LAST-1];
      out_r.digits  <= dd_r[s2da_pkg::DD_STAGES].bcd;
      out_r.top_idx <= s2da_pkg::top_digit(dd_r[s2da_pkg::DD_STAGES].bcd);
    end
  end

  // no word is taken while reset is held
  assign i_ready = rdy[0] && rst_n;
  assign o_valid = v_r[LAST];
  assign o_conv  = out_r;

`ifndef ASSERT_OFF
  // the sign rides along with the digits of the same word
  a_neg_follow: assert property (@(posedge clk) disable iff (!rst_n)
    rdy[LAST] && v_r[LAST-1] |=> out_r.neg == neg_r[LAST])
    else $error("sign lost between last two stages");

  // a held result stage never moves while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && !o_ready |=> o_valid && $stable(out_r))
    else $error("conversion result changed under stall");

  // digit index never points past the digit array
  a_top: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> out_r.top_idx < s2da_pkg::IDX_W'(s2da_pkg::NUM_DIGITS))
    else $error("digit index out of range");
`endif

endmodule

// ----- rtl/s2da_ser.sv -----
module s2da_ser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            i_valid,
  output logic                            i_ready,
  input  s2da_pkg::conv_t                 i_conv,
  output logic                            o_valid,
  input  logic                            o_ready,
  output logic [s2da_pkg::CHAR_W-1:0]     o_char,
  output logic                            o_last
);

  logic                                  busy_r;
  logic                                  sign_r;
  logic [s2da_pkg::IDX_W-1:0]            idx_r;
  logic [s2da_pkg::NUM_DIGITS-1:0][3:0]  digits_r;
  logic                                  take;

  assign o_valid = busy_r;
  assign o_last  = !sign_r && (idx_r == '0);
  assign o_char  = sign_r ? s2da_pkg::ASCII_MINUS
                          : s2da_pkg::ASCII_ZERO + {4'd0, digits_r[idx_r]};
  // next number loads as the last character of the current one leaves
  assign i_ready = !busy_r || (o_ready && o_last);
  assign take    = i_valid && i_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      idx_r  <= '0;
    end else if (take) begin
      busy_r   <= 1'b1;
      sign_r   <= i_conv.neg;
      idx_r    <= i_conv.top_idx;
      digits_r <= i_conv.digits;
    end else if (busy_r && o_ready) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else if (idx_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy_r)
    else $error("serializer busy after reset");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid |-> (o_char == s2da_pkg::ASCII_MINUS) ||
                (o_char >= s2da_pkg::ASCII_ZERO && o_char <= s2da_pkg::ASCII_ZERO + 8'd9))
    else $error("character outside sign and digits");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && sign_r |-> !o_last)
    else $error("sign marked as last character");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid && o_ready && !sign_r && !o_last && !take |=> idx_r == $past(idx_r) - 1'b1)
    else $error("digit index skipped");
`endif

endmodule

// ----- tb/decimal_text_checker.sv -----
module decimal_text_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  output int          mismatches,
  output int          chars_pending,
  output int          chars_checked
);

  typedef struct packed {
    logic [s2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } text_char_t;

  text_char_t expected_text[$];
  int         fail_total = 0;
  int         char_total = 0;

  // sign, then digits most significant first, last one marked
  function automatic void queue_decimal_text(logic [31:0] value);
    logic [31:0] mag;
    logic [3:0]  digit [s2da_pkg::NUM_DIGITS];
    int          n;
    text_char_t  c;
    n   = 0;
    mag = value;
    if (value[31]) begin
      mag    = ~value + 32'd1;
      c.ch   = s2da_pkg::ASCII_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    while (n == 0 || mag != 32'd0) begin
      digit[n] = 4'(mag % 32'd10);
      mag      = mag / 32'd10;
      n++;
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.ch   = s2da_pkg::ASCII_ZERO + s2da_pkg::CHAR_W'(digit[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      // compare first so a stray char never matches a word taken this cycle
      if (out_tvalid && out_tready) begin
        char_total++;
        if (expected_text.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) begin
            $display("unexpected char 8'h%02h last=%0b with nothing pending",
                     out_tdata, out_tlast);
          end
        end else begin
          want = expected_text.pop_front();
          if (out_tdata !== want.ch || out_tlast !== want.last) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("char %0d mismatch: expected 8'h%02h last=%0b, got 8'h%02h last=%0b",
                       char_total, want.ch, want.last, out_tdata, out_tlast);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        queue_decimal_text(in_tdata);
      end
    end
    mismatches    <= fail_total;
    chars_pending <= expected_text.size();
    chars_checked <= char_total;
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;

  localparam int RESET_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, fills the pipeline
  localparam int WATCHDOG_LIMIT = 2000;  // well above the hold-off plus latency
  localparam int DRAIN_CYCLES   = 40;    // wait after the checker's backlog is empty
  localparam int NUM_RANDOM     = 340;
  localparam int PRESSURE_START = 100;
  localparam int PRESSURE_END   = 140;
  localparam int QUIET_START    = 200;
  localparam int QUIET_END      = 260;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  int mismatches;
  int chars_pending;
  int chars_checked;

  // handshake between the stimulus and the receiver process
  int   holds_asked = 0;
  int   holds_done  = 0;
  logic no_idle     = 1'b0;

  int numbers_sent = 0;
  int negatives    = 0;
  int zeros        = 0;
  int idle_cycles  = 0;

  always #4 clk = ~clk;

  signed_int_to_decimal_ascii dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  decimal_text_checker u_text_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic longint ten_to(int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // random number drawn from several shapes so every digit count shows up
  function automatic logic [31:0] random_number();
    longint mag;
    int     d;
    int     kind;
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin
        // full 32-bit pattern, every bit toggles
        return $urandom;
      end
      1: begin
        // uniform within a chosen digit count
        d   = $urandom_range(1, 9);
        mag = ten_to(d - 1) + longint'($urandom) % (ten_to(d) - ten_to(d - 1));
        if (d == 1) begin
          mag = $urandom_range(0, 9);
        end
      end
      2: begin
        // just around a power of ten, where the digit count changes
        d   = $urandom_range(1, 9);
        mag = ten_to(d) + $urandom_range(0, 2) - 1;
      end
      default: begin
        mag = $urandom_range(0, 20);
      end
    endcase
    return $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
  endfunction

  // offer one word after an optional gap and wait until it is taken;
  // valid is lowered only when a gap follows, so it never drops and rises
  // in the same step
  task automatic send_number(logic [31:0] value, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    numbers_sent++;
    if (value[31]) negatives++;
    if (value == 32'd0) zeros++;
  endtask

  // receiver: alternating ready and stall spells, a long hold-off on request,
  // and always ready during the quiet stretch
  always @(posedge clk) begin
    static int   spell_left  = 0;
    static int   hold_left   = 0;
    static logic ready_spell = 1'b1;
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done = holds_done + 1;
      hold_left  = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      if (spell_left == 0) begin
        if (ready_spell) begin
          stall = pick_gap();
          if (stall > 0) begin
            ready_spell = 1'b0;
            spell_left  = stall;
          end else begin
            spell_left = $urandom_range(1, 12);
          end
        end else begin
          ready_spell = 1'b1;
          spell_left  = $urandom_range(1, 12);
        end
      end
      spell_left--;
      out_tready <= ready_spell;
    end
  end

  // watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d chars still pending",
               idle_cycles, chars_pending);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] directed [$];
    int          gap;

    // extremes, sign handling, digit count boundaries, alternating bits
    directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
                 32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 32'd1000000000, -32'sd1000000000, 32'd999999999,
                 -32'sd999999999, 32'd2000000000, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'd1234567890, -32'sd1234567890, 32'd7};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_number(directed[i], pick_gap());
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // pressure: receiver holds off while the sender keeps offering
      if (n == PRESSURE_START) begin
        holds_asked <= holds_asked + 1;
      end
      if (n == QUIET_START) begin
        no_idle <= 1'b1;
      end else if (n == QUIET_END) begin
        no_idle <= 1'b0;
      end
      if ((n >= PRESSURE_START && n < PRESSURE_END) ||
          (n >= QUIET_START && n < QUIET_END)) begin
        gap = 0;
      end else begin
        gap = pick_gap();
      end
      send_number(random_number(), gap);
    end

    in_tvalid <= 1'b0;

    // let the checker see the last word before reading its backlog
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d numbers (%0d negative, %0d zero), %0d characters checked",
             numbers_sent, negatives, zeros, chars_checked);
    $display("receiver held off once for %0d cycles, plus random stalls on both sides",
             HOLD_CYCLES);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d chars never arrived", mismatches, chars_pending);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/s2da_pkg.sv
rtl/s2da_conv.sv
rtl/s2da_ser.sv
rtl/signed_int_to_decimal_ascii.sv
tb/decimal_text_checker.sv
tb/testbench.sv
